FILE: design/bdl_pkg.sv
`timescale 1ns / 1ps

package bdl_pkg;

   // Operation codes carried on req_func.
   typedef enum logic [3:0] {
      FN_INS_HEAD   = 4'd0,
      FN_INS_TAIL   = 4'd1,
      FN_REM_HEAD   = 4'd2,
      FN_REM_TAIL   = 4'd3,
      FN_READ_IDX   = 4'd4,
      FN_WRITE_IDX  = 4'd5,
      FN_CLEAR      = 4'd6,
      FN_READ_HEAD  = 4'd7,
      FN_READ_TAIL  = 4'd8
   } func_type;

   // Result codes carried on rsp_status.
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BOUNDS = 2'd3
   } status_type;

   localparam int FUNC_W   = 4;
   localparam int POS_W    = 9;
   localparam int ITEM_W   = 32;
   localparam int RDVAL_W  = 32;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;   // a request is accepted this cycle
      logic load;   // move the finished result into the response register
   } ctl_cmd_type;

endpackage

FILE: design/bounded_deque_list_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  req_func, req_position, req_item
// rsp_      out        rsp_valid/rsp_ready  rsp_read_value, rsp_count, rsp_status
//
// The idle state accepts a request and issues its single element RAM access,
// if any; the execute state moves the registered RAM read to the response register.
// A new request is taken while an earlier response still waits on rsp_ready.
// Reset is synchronous; it empties the list without touching the RAM contents.
// A stalled response holds the unit in its execute state until the response leaves.

module bounded_deque_list_unit #(
   parameter int CAPACITY   = 256,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bdl_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [bdl_pkg::POS_W-1:0]  req_position,
   input  logic [bdl_pkg::ITEM_W-1:0]        req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bdl_pkg::RDVAL_W-1:0]       rsp_read_value,
   output logic [bdl_pkg::COUNT_W-1:0]       rsp_count,
   output logic [bdl_pkg::STATUS_W-1:0]      rsp_status
);

   bdl_pkg::ctl_cmd_type cmd;

   bdl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   bdl_dpath #(
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_func       (req_func),
      .req_position   (req_position),
      .req_item       (req_item),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_status     (rsp_status)
   );

endmodule

FILE: design/bdl_ram.sv
`timescale 1ns / 1ps

module bdl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/bdl_ctrl.sv
`timescale 1ns / 1ps

module bdl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bdl_pkg::ctl_cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      valid_ff;
   logic      take;
   logic      load;

   assign take = req_valid && ready_ff;
   // The result may move out once the response register is free or being emptied.
   assign load = (state_ff == S_EXEC) && (!valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (take) begin
                  state_ff <= S_EXEC;
                  ready_ff <= 1'b0;
               end else begin
                  ready_ff <= 1'b1;
               end
            end
            S_EXEC: begin
               if (load) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b0;
            end
         endcase
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = ready_ff;
   assign rsp_valid = valid_ff;
   assign cmd.take  = take;
   assign cmd.load  = load;

endmodule

FILE: design/bdl_dpath.sv
`timescale 1ns / 1ps

module bdl_dpath #(
   parameter int CAPACITY   = 256,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bdl_pkg::ctl_cmd_type                 cmd,
   input  logic [bdl_pkg::FUNC_W-1:0]           req_func,
   input  logic signed [bdl_pkg::POS_W-1:0]     req_position,
   input  logic [bdl_pkg::ITEM_W-1:0]           req_item,
   output logic [bdl_pkg::RDVAL_W-1:0]          rsp_read_value,
   output logic [bdl_pkg::COUNT_W-1:0]          rsp_count,
   output logic [bdl_pkg::STATUS_W-1:0]         rsp_status
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > bdl_pkg::POS_W - 1) ? CW : bdl_pkg::POS_W - 1;
   localparam int XW = (CW > bdl_pkg::COUNT_W) ? CW : bdl_pkg::COUNT_W;
   localparam logic [AW:0]   CAP_S  = (AW + 1)'(CAPACITY);
   localparam logic [AW-1:0] LAST   = AW'(CAPACITY - 1);
   localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);

   logic [AW-1:0]                  head_ff, head_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [CW-1:0]                  wk_count_ff;
   logic [bdl_pkg::STATUS_W-1:0]   wk_status_ff, status_in;
   logic                           wk_read_ff, rd_en;
   logic [bdl_pkg::RDVAL_W-1:0]    rsp_read_value_ff;
   logic [bdl_pkg::COUNT_W-1:0]    rsp_count_ff;
   logic [bdl_pkg::STATUS_W-1:0]   rsp_status_ff;

   logic                    empty, full, pos_neg, pos_over;
   logic [PW-1:0]           pos_ext, cnt_ext;
   logic [AW-1:0]           cnt_last, offset, slot, dec_head;
   logic [AW:0]             slot_sum;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [63:0]             item_wide, rd_wide;
   logic [ELEM_WIDTH-1:0]   wr_data, rd_data;
   logic [XW-1:0]           cnt_wide;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CAP_C);
   assign pos_neg  = req_position[bdl_pkg::POS_W-1];
   assign pos_ext  = PW'(req_position[bdl_pkg::POS_W-2:0]);
   assign cnt_ext  = PW'(count_ff);
   assign pos_over = (pos_ext >= cnt_ext);
   assign cnt_last = AW'(count_ff - CW'(1));
   assign dec_head = (head_ff == '0) ? LAST : head_ff - AW'(1);

   // Ring slot of the element at the selected offset from the head.
   assign slot_sum = {1'b0, head_ff} + {1'b0, offset};
   assign slot     = (slot_sum >= CAP_S) ? AW'(slot_sum - CAP_S) : AW'(slot_sum);

   assign item_wide = 64'(req_item);
   assign wr_data   = item_wide[ELEM_WIDTH-1:0];

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = bdl_pkg::ST_OK;
      offset    = '0;
      wr_en     = 1'b0;
      wr_addr   = slot;
      rd_en     = 1'b0;
      unique case (req_func)
         bdl_pkg::FN_INS_HEAD: begin
            if (full) begin
               status_in = bdl_pkg::ST_FULL;
            end else begin
               head_in  = dec_head;
               wr_addr  = dec_head;
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         bdl_pkg::FN_INS_TAIL: begin
            offset = AW'(count_ff);
            if (full) begin
               status_in = bdl_pkg::ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         bdl_pkg::FN_REM_HEAD: begin
            offset = AW'(1);
            if (empty) begin
               status_in = bdl_pkg::ST_EMPTY;
            end else begin
               head_in  = slot;
               count_in = count_ff - CW'(1);
            end
         end
         bdl_pkg::FN_REM_TAIL: begin
            if (empty) begin
               status_in = bdl_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         bdl_pkg::FN_READ_IDX: begin
            // Negative positions clamp to the first element, large ones to the last.
            if (pos_neg) begin
               offset = '0;
            end else if (pos_over) begin
               offset = cnt_last;
            end else begin
               offset = AW'(pos_ext);
            end
            if (empty) begin
               status_in = bdl_pkg::ST_EMPTY;
            end else begin
               rd_en = 1'b1;
            end
         end
         bdl_pkg::FN_WRITE_IDX: begin
            offset = AW'(pos_ext);
            if (empty) begin
               status_in = bdl_pkg::ST_EMPTY;
            end else if (pos_neg || pos_over) begin
               status_in = bdl_pkg::ST_BOUNDS;
            end else begin
               wr_en = 1'b1;
            end
         end
         bdl_pkg::FN_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         bdl_pkg::FN_READ_HEAD: begin
            if (empty) begin
               status_in = bdl_pkg::ST_EMPTY;
            end else begin
               rd_en = 1'b1;
            end
         end
         bdl_pkg::FN_READ_TAIL: begin
            offset = cnt_last;
            if (empty) begin
               status_in = bdl_pkg::ST_EMPTY;
            end else begin
               rd_en = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   bdl_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en && cmd.take),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en && cmd.take),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.take) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // The RAM output holds until the next read, so the result may wait here.
   assign rd_wide  = 64'(rd_data);
   assign cnt_wide = XW'(wk_count_ff);

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         wk_count_ff  <= count_in;
         wk_status_ff <= status_in;
         wk_read_ff   <= rd_en;
      end
      if (cmd.load) begin
         rsp_read_value_ff <= wk_read_ff ? rd_wide[bdl_pkg::RDVAL_W-1:0] : '0;
         rsp_count_ff      <= cnt_wide[bdl_pkg::COUNT_W-1:0];
         rsp_status_ff     <= wk_status_ff;
      end
   end

   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
